>>> hdl/ecf_pkg.sv
// Echo / reverb comb filter: shared constants, types and helper functions.
// Used by every module of the block but the RAM and the checker; depends on nothing.

package ecf_pkg;

   // Storage and field sizes
   localparam int DELAY_DEPTH    = 32768;
   localparam int SAMPLE_BITS    = 32;
   localparam int ADDR_BITS      = $clog2(DELAY_DEPTH);
   localparam int DLY_BITS       = ADDR_BITS + 1;
   localparam int CFG_DELAY_BITS = 16;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC      = 15;
   localparam int SEEN_BITS      = 16;
   localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS - GAIN_FRAC;
   localparam int SUM_BITS       = PROD_BITS + 1;

   // Result queue: one entry for every request the pipeline can hold
   localparam int RSP_DEPTH      = 4;
   localparam int RSP_PTR_BITS   = $clog2(RSP_DEPTH);
   localparam int CREDIT_BITS    = $clog2(RSP_DEPTH + 1);

   // Register port
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CFG_DELAY_BITS-1:0] DELAY_RESET = CFG_DELAY_BITS'(24000);
   localparam logic [GAIN_BITS-1:0]      GAIN_RESET  = GAIN_BITS'(16384);
   localparam logic [SEEN_BITS-1:0]      SEEN_MAX    = '1;

   typedef enum logic [1:0] {
      REG_MODE  = 2'd0,
      REG_DELAY = 2'd1,
      REG_GAIN  = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_ECHO   = 1'b0,
      MODE_REVERB = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic [CFG_DELAY_BITS-1:0] delay;
      logic [GAIN_BITS-1:0]      gain;
   } cfg_type;

   typedef struct packed {
      logic                   last;
      logic [SAMPLE_BITS-1:0] sample;
   } rsp_type;

   // Delay actually used: zero acts as one, anything past the line depth is clipped
   function automatic logic [DLY_BITS-1:0] eff_delay(input logic [CFG_DELAY_BITS-1:0] dly);
      int unsigned v;
      v = 32'(dly);
      if (v == 0) v = 1;
      if (v > DELAY_DEPTH) v = DELAY_DEPTH;
      return DLY_BITS'(v);
   endfunction

endpackage

>>> hdl/ecf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address written in the same cycle returns the old contents.
// No dependencies.

module ecf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ecf_csr.sv
// Register block: mode, delay and gain behind the APB-style port.
// Depends on ecf_pkg.

module ecf_csr
   import ecf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type idx;
   logic          wr_strobe;

   assign idx       = csr_index_type'(csr_paddr[3:2]);
   assign wr_strobe = csr_psel && csr_penable && csr_pwrite;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (idx)
            REG_MODE:  cfg_in.mode  = mode_type'(csr_pwdata[0]);
            REG_DELAY: cfg_in.delay = csr_pwdata[CFG_DELAY_BITS-1:0];
            REG_GAIN:  cfg_in.gain  = csr_pwdata[GAIN_BITS-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode  <= MODE_ECHO;
         cfg_ff.delay <= DELAY_RESET;
         cfg_ff.gain  <= GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back
   always_comb begin
      case (idx)
         REG_MODE:  csr_prdata = CSR_DATA_BITS'(cfg_ff.mode);
         REG_DELAY: csr_prdata = CSR_DATA_BITS'(cfg_ff.delay);
         REG_GAIN:  csr_prdata = CSR_DATA_BITS'(cfg_ff.gain);
         default:   csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

>>> hdl/ecf_filter.sv
// Comb filter datapath: delay-line address generation, RAM read, forwarding,
// Q1.15 multiply, saturating add and write-back. Depends on ecf_pkg, ecf_ram.

module ecf_filter
   import ecf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   in_accept,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   input  logic                   in_last,
   output logic                   hazard,
   output logic                   out_valid,
   output rsp_type                out_rsp
);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] x;
      logic                   last;
      logic                   active;
      logic [ADDR_BITS-1:0]   wp;
      logic [ADDR_BITS-1:0]   rp;
   } sta_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] x;
      logic                   last;
      logic                   active;
      logic [ADDR_BITS-1:0]   wp;
      logic [PROD_BITS-1:0]   prod;
   } stb_type;

   localparam logic [ADDR_BITS:0]     DEPTH_X   = (ADDR_BITS+1)'(DELAY_DEPTH);
   localparam logic [ADDR_BITS-1:0]   WP_LAST   = ADDR_BITS'(DELAY_DEPTH - 1);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

   logic [ADDR_BITS-1:0]   wp_ff, wp_in;
   logic [SEEN_BITS-1:0]   seen_ff, seen_in;
   logic                   sta_valid_ff, sta_valid_in;
   sta_type                sta_ff, sta_in;
   logic                   stb_valid_ff, stb_valid_in;
   stb_type                stb_ff, stb_in;
   logic                   wr_valid_ff, wr_valid_in;
   logic [ADDR_BITS-1:0]   wr_addr_ff, wr_addr_in;
   logic [SAMPLE_BITS-1:0] wr_data_ff, wr_data_in;

   logic [DLY_BITS-1:0]    dly;
   logic [ADDR_BITS:0]     wp_x, rp_x;
   logic [ADDR_BITS-1:0]   rp;
   logic                   active;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic [SAMPLE_BITS-1:0] past;
   logic [SAMPLE_BITS+GAIN_BITS-1:0] full_prod;
   logic [SUM_BITS-1:0]    sum;
   logic [SAMPLE_BITS-1:0] y;
   logic [SAMPLE_BITS-1:0] ram_wdata;

   // Read address, delay-reached flag and counters at request time
   always_comb begin
      dly    = eff_delay(cfg.delay);
      wp_x   = {1'b0, wp_ff};
      if (wp_x >= dly) rp_x = wp_x - dly;
      else             rp_x = wp_x + DEPTH_X - dly;
      rp     = rp_x[ADDR_BITS-1:0];
      active = 32'(seen_ff) >= 32'(dly);

      wp_in   = wp_ff;
      seen_in = seen_ff;
      if (in_accept) begin
         wp_in = (wp_ff == WP_LAST) ? '0 : wp_ff + 1'b1;
         if (in_last)                seen_in = '0;
         else if (seen_ff != SEEN_MAX) seen_in = seen_ff + 1'b1;
      end
   end

   // Reverb with a one-sample delay: the entry is still being computed in stage A
   assign hazard = sta_valid_ff && (sta_ff.wp == rp) && (cfg.mode == MODE_REVERB) && active;

   // Stage A load
   always_comb begin
      sta_valid_in = in_accept;
      sta_in.x      = in_sample;
      sta_in.last   = in_last;
      sta_in.active = active;
      sta_in.wp     = wp_ff;
      sta_in.rp     = rp;
   end

   // Stage A: pick the newest copy of the delayed entry, then multiply
   always_comb begin
      if (stb_valid_ff && (stb_ff.wp == sta_ff.rp) && (cfg.mode == MODE_ECHO)) begin
         past = stb_ff.x;
      end else if (wr_valid_ff && (wr_addr_ff == sta_ff.rp)) begin
         past = wr_data_ff;
      end else begin
         past = rd_data;
      end
      full_prod    = past * cfg.gain;
      stb_valid_in = sta_valid_ff;
      stb_in.x      = sta_ff.x;
      stb_in.last   = sta_ff.last;
      stb_in.active = sta_ff.active;
      stb_in.wp     = sta_ff.wp;
      stb_in.prod   = full_prod[SAMPLE_BITS+GAIN_BITS-1:GAIN_FRAC];
   end

   // Stage B: saturating add and write-back
   always_comb begin
      sum = SUM_BITS'(stb_ff.x) + SUM_BITS'(stb_ff.prod);
      if (!stb_ff.active)                     y = stb_ff.x;
      else if (|sum[SUM_BITS-1:SAMPLE_BITS])  y = SAMPLE_MAX;
      else                                    y = sum[SAMPLE_BITS-1:0];
      ram_wdata   = (cfg.mode == MODE_REVERB) ? y : stb_ff.x;
      wr_valid_in = stb_valid_ff;
      wr_addr_in  = stb_ff.wp;
      wr_data_in  = ram_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         seen_ff      <= '0;
         sta_valid_ff <= 1'b0;
         stb_valid_ff <= 1'b0;
         wr_valid_ff  <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         sta_valid_ff <= sta_valid_in;
         stb_valid_ff <= stb_valid_in;
         wr_valid_ff  <= wr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sta_ff     <= sta_in;
      stb_ff     <= stb_in;
      wr_addr_ff <= wr_addr_in;
      wr_data_ff <= wr_data_in;
   end

   ecf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DELAY_DEPTH)
   ) u_delay_line (
      .clock   (clock),
      .wr_en   (stb_valid_ff),
      .wr_addr (stb_ff.wp),
      .wr_data (ram_wdata),
      .rd_addr (rp),
      .rd_data (rd_data)
   );

   assign out_valid      = stb_valid_ff;
   assign out_rsp.last   = stb_ff.last;
   assign out_rsp.sample = y;

endmodule

>>> hdl/ecf_rsp_fifo.sv
// Small result queue between the filter pipeline and the output channel.
// Depends on ecf_pkg.

module ecf_rsp_fifo
   import ecf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_rsp,
   input  logic    pop,
   output logic    not_empty,
   output rsp_type head_rsp
);

   rsp_type                 entry_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wptr_ff, wptr_in;
   logic [RSP_PTR_BITS-1:0] rptr_ff, rptr_in;
   logic [CREDIT_BITS-1:0]  count_ff, count_in;

   // Pointer and fill bookkeeping
   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_rsp;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_rsp  = entry_ff[rptr_ff];

endmodule

>>> hdl/echo_reverb_comb_filter.sv
// Echo / reverb comb filter top level. A request passes through stage A, stage B and
// the result queue. Throughput: one request per cycle while the queue has room; in reverb
// mode with a delay of one sample a request waits until the previous one has left stage A,
// set by the multiply-add feeding the next read of the same delay-line entry.
// Reset (synchronous, active high) clears counters, pipeline and queue, and loads
// mode echo, delay 24000, gain 16384; the delay-line RAM is not cleared.

module echo_reverb_comb_filter
   import ecf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [31:0]              req_tdata,   // [31:0] sample_in
   input  logic                     req_tlast,
   // result channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata,   // [31:0] sample_out
   output logic                     rsp_tlast,
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type                cfg;
   logic                   hazard;
   logic                   req_accept;
   logic                   rsp_accept;
   logic                   pipe_valid;
   rsp_type                pipe_rsp;
   rsp_type                head_rsp;
   logic [CREDIT_BITS-1:0] inflight_ff, inflight_in;

   // Requests in flight, held or queued; bounded by the queue depth
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign req_tready = !reset && (inflight_ff != CREDIT_BITS'(RSP_DEPTH)) && !hazard;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_accept && !rsp_accept)      inflight_in = inflight_ff + 1'b1;
      else if (!req_accept && rsp_accept) inflight_in = inflight_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   ecf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ecf_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_accept (req_accept),
      .in_sample (req_tdata[SAMPLE_BITS-1:0]),
      .in_last   (req_tlast),
      .hazard    (hazard),
      .out_valid (pipe_valid),
      .out_rsp   (pipe_rsp)
   );

   ecf_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (pipe_valid),
      .push_rsp  (pipe_rsp),
      .pop       (rsp_accept),
      .not_empty (rsp_tvalid),
      .head_rsp  (head_rsp)
   );

   assign rsp_tdata = head_rsp.sample;
   assign rsp_tlast = head_rsp.last;

endmodule

>>> hdl/ecf_checker.sv
// Port-level checks for the echo / reverb comb filter, bound to the top level.
// Depends on echo_reverb_comb_filter.

module ecf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // No request is taken while reset is held
   a_no_req_in_reset: assert property (@(posedge clock)
      reset |-> !req_tready)
      else $error("request channel ready during reset");

   // Reset empties the result queue
   a_rsp_cleared: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A result showing up on an empty channel follows a request by the pipeline depth
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))
      else $error("result without a matching request");

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind echo_reverb_comb_filter ecf_checker u_ecf_checker (.*);

>>> tb/echo_reverb_comb_filter_tb.sv
// Testbench for the echo / reverb comb filter: directed and random stream requests,
// register writes over the APB-style port, and a self-checking scoreboard.
// Depends on ecf_pkg and the echo_reverb_comb_filter top level.
`timescale 1ns / 1ps

module echo_reverb_comb_filter_tb
   import ecf_pkg::*;
();

   localparam int CLK_HALF_NS   = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int RAND_PHASES   = 8;
   localparam int PHASE_ITEMS   = 144;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 40;
   localparam longint TIMEOUT_NS = 64'd20_000_000;

   // Scoreboard: bit-accurate comb filter predictor plus the queue of expected samples
   class comb_scoreboard;
      logic [SAMPLE_BITS-1:0]    history [DELAY_DEPTH];
      logic [ADDR_BITS-1:0]      wr_pos;
      logic [SEEN_BITS-1:0]      file_count;
      mode_type                  mode;
      logic [CFG_DELAY_BITS-1:0] delay;
      logic [GAIN_BITS-1:0]      gain;
      rsp_type                   expected_out [$];
      int                        errors;

      function new();
         errors = 0;
         reset_state();
      endfunction

      function void reset_state();
         wr_pos     = '0;
         file_count = '0;
         mode       = MODE_ECHO;
         delay      = 16'd24000;
         gain       = 16'd16384;
         expected_out.delete();
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            REG_MODE:  mode  = mode_type'(value[0]);
            REG_DELAY: delay = value[CFG_DELAY_BITS-1:0];
            REG_GAIN:  gain  = value[GAIN_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_out.size();
      endfunction

      // One request in, one filtered sample expected out
      function void filter_request(logic [SAMPLE_BITS-1:0] x, logic last);
         int unsigned           d;
         logic [ADDR_BITS-1:0]  rd_pos;
         logic [63:0]           sum;
         logic [SAMPLE_BITS-1:0] y;
         rsp_type               r;
         d = delay;
         if (d == 0) d = 1;
         if (d > DELAY_DEPTH) d = DELAY_DEPTH;
         y = x;
         if (file_count >= d) begin
            rd_pos = ADDR_BITS'(wr_pos - d);
            sum = 64'(x) + ((64'(history[rd_pos]) * 64'(gain)) >> GAIN_FRAC);
            y = (sum > 64'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : sum[31:0];
         end
         history[wr_pos] = (mode == MODE_REVERB) ? y : x;
         wr_pos = wr_pos + 1'b1;
         if (last) file_count = '0;
         else if (file_count != SEEN_MAX) file_count = file_count + 1'b1;
         r.sample = y;
         r.last   = last;
         expected_out.push_back(r);
      endfunction

      function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
      endfunction

      function void check_result(logic [SAMPLE_BITS-1:0] sample, logic last);
         rsp_type e;
         if (expected_out.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t ns: result %h with no request pending", $time, sample);
            return;
         end
         e = expected_out.pop_front();
         if (sample !== e.sample) report("sample", e.sample, sample);
         if (last !== e.last) report("last", 32'(e.last), 32'(last));
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [31:0]              req_tdata;   // [31:0] sample_in
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [31:0]              rsp_tdata;   // [31:0] sample_out
   logic                     rsp_tlast;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   comb_scoreboard sb = new();

   echo_reverb_comb_filter uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF_NS clock = ~clock;
   end

   // Safety net against a hung handshake
   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor both channels at the sampling edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.filter_request(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_sample(input logic [31:0] s, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop sending and let every outstanding result come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Setup cycle then access cycle; upper bits carry junk the block must ignore
   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_filter(input mode_type m, input logic [15:0] d, input logic [15:0] g);
      logic [31:0] junk;
      wait_drained();
      junk = $urandom;
      csr_write(REG_MODE,  {junk[31:1], 1'(m)});
      csr_write(REG_DELAY, {junk[15:0], d});
      csr_write(REG_GAIN,  {junk[31:16], g});
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(7))
         0:       return 32'hFFFF_FFFF;
         1:       return 32'h0;
         2, 3:    return $urandom;
         default: return $urandom >> $urandom_range(4, 16);
      endcase
   endfunction

   function automatic logic [15:0] pick_delay();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'd2;
         default: return 16'($urandom_range(3, 48));
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(6))
         0:       return 16'd0;
         1:       return 16'd32768;
         2:       return 16'hFFFF;
         3:       return 16'd9830;
         4:       return 16'd16384;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      int          phase;
      int          left;
      int          pause_at;
      int          len;
      int          d_eff;
      logic [15:0] d_cfg;
      mode_type    m;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      sb.reset_state();
      @(negedge clock);

      // Directed: zero delay acts as one, unity gain, saturation
      set_filter(MODE_ECHO, 16'd0, 16'd32768);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0001, 1'b1);

      // Reverb with gain just under two
      set_filter(MODE_REVERB, 16'd2, 16'hFFFF);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h0000_0002, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b1);

      // Zero gain, then a mode switch in the middle of the same file
      set_filter(MODE_ECHO, 16'd3, 16'd0);
      send_sample(32'hA5A5_A5A5, 1'b0);
      send_sample(32'h5A5A_5A5A, 1'b0);
      send_sample(32'h1234_5678, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      set_filter(MODE_REVERB, 16'd3, 16'd9830);
      send_sample(32'h0F0F_0F0F, 1'b0);
      send_sample(32'hF0F0_F0F0, 1'b0);
      send_sample(32'h0000_FFFF, 1'b0);
      send_sample(32'hFFFF_0000, 1'b1);

      // Delay past the line depth clips to the depth
      set_filter(MODE_ECHO, 16'hFFFF, 16'd16384);
      send_sample(32'hDEAD_BEEF, 1'b0);
      send_sample(32'h0000_0003, 1'b1);

      // Random phases: files mostly longer than the delay, some cut short or split
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         m     = mode_type'((phase ^ (phase >> 2)) & 1);
         d_cfg = pick_delay();
         set_filter(m, d_cfg, pick_gain());
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         d_eff    = (d_cfg == 0) ? 1 : int'(d_cfg);
         left     = PHASE_ITEMS;
         pause_at = $urandom_range(20, 120);
         while (left > 0) begin
            if ($urandom_range(4) == 0) len = $urandom_range(1, d_eff);
            else len = $urandom_range(d_eff + 1, 3 * d_eff + 8);
            for (int i = 0; i < len && left > 0; i++) begin
               if (left == pause_at) wait_drained();
               send_sample(pick_sample(), i == len - 1);
               left--;
            end
         end
      end

      wait_drained();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
hdl/ecf_pkg.sv
hdl/ecf_ram.sv
hdl/ecf_csr.sv
hdl/ecf_filter.sv
hdl/ecf_rsp_fifo.sv
hdl/echo_reverb_comb_filter.sv
hdl/ecf_checker.sv
tb/echo_reverb_comb_filter_tb.sv
